>>> design/smf_pkg.sv
// Shared types, constants and CRC helper for the speed command Modbus framer.
`timescale 1ns / 1ps

package smf_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned FrameLen = 16;
	localparam int unsigned ByteCntW = $clog2(FrameLen);

	localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [8:0] SPEED_CLAMP = 9'd400;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SPEED_OFFSET = 3'd0,
		CFG_SPEED_GAIN   = 3'd1,
		CFG_RPM_LIMIT    = 3'd2,
		CFG_FIRST_ADDR   = 3'd3,
		CFG_SECOND_ADDR  = 3'd4,
		CFG_SPEED_REG    = 3'd5,
		CFG_DRIVE_REG    = 3'd6,
		CFG_DIR_CODES    = 3'd7
	} cfg_idx_t;

	// One command on its way to the byte serializer
	typedef struct packed {
		logic        sel;
		logic [7:0]  slave;
		logic [15:0] rpm;
		logic [15:0] code;
		logic [15:0] crc_spd;
		logic [15:0] crc_drv;
	} frame_t;

	// CRC-16/MODBUS update by one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> design/smf_serializer.sv
// Holds one finished command and sends its two frames one byte per transfer.
`timescale 1ns / 1ps

module smf_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ld_valid,
	output logic                 ld_ready,
	input  smf_pkg::frame_t      ld_frame,
	input  logic [15:0]          spd_reg,
	input  logic [15:0]          drv_reg,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           frame_byte,
	output logic                 port,
	output logic                 last
);

	logic                           busy_q;
	logic [smf_pkg::ByteCntW-1:0]   cnt_q;
	smf_pkg::frame_t                fr_q;
	logic                           end_xfer;
	logic                           load;
	logic [smf_pkg::FrameLen-1:0][7:0] bytes;

	assign end_xfer = busy_q && !out_stall
		&& (cnt_q == smf_pkg::ByteCntW'(smf_pkg::FrameLen - 1));
	assign ld_ready = !busy_q || end_xfer;
	assign load = ld_valid && ld_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (end_xfer) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q && !out_stall) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fr_q <= ld_frame;
		end
	end

	// Speed frame, then drive frame; CRC goes low byte first
	always_comb begin
		bytes[0]  = fr_q.slave;
		bytes[1]  = smf_pkg::FUNC_WRITE_SINGLE;
		bytes[2]  = spd_reg[15:8];
		bytes[3]  = spd_reg[7:0];
		bytes[4]  = fr_q.rpm[15:8];
		bytes[5]  = fr_q.rpm[7:0];
		bytes[6]  = fr_q.crc_spd[7:0];
		bytes[7]  = fr_q.crc_spd[15:8];
		bytes[8]  = fr_q.slave;
		bytes[9]  = smf_pkg::FUNC_WRITE_SINGLE;
		bytes[10] = drv_reg[15:8];
		bytes[11] = drv_reg[7:0];
		bytes[12] = fr_q.code[15:8];
		bytes[13] = fr_q.code[7:0];
		bytes[14] = fr_q.crc_drv[7:0];
		bytes[15] = fr_q.crc_drv[15:8];
	end

	assign out_valid  = busy_q;
	assign frame_byte = bytes[cnt_q];
	assign port       = fr_q.sel;
	assign last       = (cnt_q == smf_pkg::ByteCntW'(smf_pkg::FrameLen - 1));

endmodule

>>> design/speed_command_modbus_framer.sv
// Path: an accepted command goes through stages 1 to 6 and then into the serializer.
// Throughput: one frame byte per cycle on the output while out_stall is low, 16 bytes per command;
// the single byte-wide output port sets that rate while the 6-stage pipeline
// holds further commands behind it.
// Reset: arst_n clears valid bits and serializer state and sets config registers to defaults.
`timescale 1ns / 1ps

module speed_command_modbus_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [smf_pkg::CfgIdxW-1:0]   wr_index,
	input  logic [smf_pkg::CfgDataW-1:0]  wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          motor_select,
	input  logic signed [15:0]            speed,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    frame_byte,
	output logic                          port,
	output logic                          last
);

	logic [11:0] offset_q;
	logic [9:0]  gain_q;
	logic [15:0] limit_q;
	logic [7:0]  addr1_q;
	logic [7:0]  addr2_q;
	logic [15:0] spd_reg_q;
	logic [15:0] drv_reg_q;
	logic [31:0] codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= 12'd0;
			gain_q    <= 10'd480;
			limit_q   <= 16'd4000;
			addr1_q   <= 8'd1;
			addr2_q   <= 8'd2;
			spd_reg_q <= 16'd0;
			drv_reg_q <= 16'd0;
			codes_q   <= 32'd0;
		end else if (wr_en) begin
			case (smf_pkg::cfg_idx_t'(wr_index))
				smf_pkg::CFG_SPEED_OFFSET: offset_q  <= wr_data[11:0];
				smf_pkg::CFG_SPEED_GAIN:   gain_q    <= wr_data[9:0];
				smf_pkg::CFG_RPM_LIMIT:    limit_q   <= wr_data[15:0];
				smf_pkg::CFG_FIRST_ADDR:   addr1_q   <= wr_data[7:0];
				smf_pkg::CFG_SECOND_ADDR:  addr2_q   <= wr_data[7:0];
				smf_pkg::CFG_SPEED_REG:    spd_reg_q <= wr_data[15:0];
				smf_pkg::CFG_DRIVE_REG:    drv_reg_q <= wr_data[15:0];
				smf_pkg::CFG_DIR_CODES:    codes_q   <= wr_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic ld_ready;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic        sel_s1, sel_s2;
	logic [7:0]  slave_s1, slave_s2;
	logic        rev_s1;
	logic [8:0]  mag_s1;
	logic [15:0] crc_s1, crc_s2;
	logic [15:0] code_s2;
	logic        nz_s2;
	logic [14:0] scaled_s2;
	smf_pkg::frame_t fr_s3, fr_s4, fr_s5, fr_s6;

	logic [16:0] mag_full;
	logic [8:0]  mag_clamp;
	logic [7:0]  slave_in;
	logic [18:0] prod;
	logic [15:0] rpm_sum;
	logic [15:0] rpm_sat;

	// Whole pipeline advances together; hold when the last stage cannot unload
	assign in_stall = v_s6 && !ld_ready;
	assign en = !in_stall;

	assign mag_full = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
	assign mag_clamp = (mag_full > 17'(smf_pkg::SPEED_CLAMP))
		? smf_pkg::SPEED_CLAMP : mag_full[8:0];
	assign slave_in = motor_select ? addr2_q : addr1_q;

	assign prod = {10'd0, mag_s1} * {9'd0, gain_q};

	assign rpm_sum = nz_s2 ? ({4'd0, offset_q} + {1'b0, scaled_s2}) : 16'd0;
	assign rpm_sat = (rpm_sum > limit_q) ? limit_q : rpm_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: clamp magnitude, pick slave, CRC over the address byte
			sel_s1   <= motor_select;
			slave_s1 <= slave_in;
			rev_s1   <= speed[15];
			mag_s1   <= mag_clamp;
			crc_s1   <= smf_pkg::crc_byte(smf_pkg::CRC_INIT, slave_in);

			// stage 2: scale by the gain, CRC over the function code
			sel_s2    <= sel_s1;
			slave_s2  <= slave_s1;
			code_s2   <= rev_s1 ? codes_q[31:16] : codes_q[15:0];
			nz_s2     <= (mag_s1 != 9'd0);
			scaled_s2 <= prod[18:4];
			crc_s2    <= smf_pkg::crc_byte(crc_s1, smf_pkg::FUNC_WRITE_SINGLE);

			// stage 3: add offset and saturate, CRC over register high bytes
			fr_s3.sel     <= sel_s2;
			fr_s3.slave   <= slave_s2;
			fr_s3.rpm     <= rpm_sat;
			fr_s3.code    <= code_s2;
			fr_s3.crc_spd <= smf_pkg::crc_byte(crc_s2, spd_reg_q[15:8]);
			fr_s3.crc_drv <= smf_pkg::crc_byte(crc_s2, drv_reg_q[15:8]);

			// stage 4: register low bytes
			fr_s4.sel     <= fr_s3.sel;
			fr_s4.slave   <= fr_s3.slave;
			fr_s4.rpm     <= fr_s3.rpm;
			fr_s4.code    <= fr_s3.code;
			fr_s4.crc_spd <= smf_pkg::crc_byte(fr_s3.crc_spd, spd_reg_q[7:0]);
			fr_s4.crc_drv <= smf_pkg::crc_byte(fr_s3.crc_drv, drv_reg_q[7:0]);

			// stage 5: data high bytes
			fr_s5.sel     <= fr_s4.sel;
			fr_s5.slave   <= fr_s4.slave;
			fr_s5.rpm     <= fr_s4.rpm;
			fr_s5.code    <= fr_s4.code;
			fr_s5.crc_spd <= smf_pkg::crc_byte(fr_s4.crc_spd, fr_s4.rpm[15:8]);
			fr_s5.crc_drv <= smf_pkg::crc_byte(fr_s4.crc_drv, fr_s4.code[15:8]);

			// stage 6: data low bytes
			fr_s6.sel     <= fr_s5.sel;
			fr_s6.slave   <= fr_s5.slave;
			fr_s6.rpm     <= fr_s5.rpm;
			fr_s6.code    <= fr_s5.code;
			fr_s6.crc_spd <= smf_pkg::crc_byte(fr_s5.crc_spd, fr_s5.rpm[7:0]);
			fr_s6.crc_drv <= smf_pkg::crc_byte(fr_s5.crc_drv, fr_s5.code[7:0]);
		end
	end

	smf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (v_s6),
		.ld_ready   (ld_ready),
		.ld_frame   (fr_s6),
		.spd_reg    (spd_reg_q),
		.drv_reg    (drv_reg_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.port       (port),
		.last       (last)
	);

`ifndef ASSERT_OFF
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted command did not reach stage 1");

	a_hold_s6: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && in_stall) |=> (v_s6 && $stable(fr_s6)))
		else $error("stalled command in last stage changed or was lost");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last && !v_s6) |=> !out_valid)
		else $error("serializer kept sending after final byte");
`endif

endmodule
